// ----- design/bod_pkg.sv -----
// Shared types and constants for the box overlap deduplicator.
`timescale 1ns / 1ps

package bod_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int COORD_BITS  = 12;

  localparam int POS_W   = COORD_BITS;
  localparam int SIZE_W  = COORD_BITS + 1;
  localparam int EDGE_W  = COORD_BITS + 2;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic              first_of_list;
    logic [POS_W-1:0]  box_x;
    logic [POS_W-1:0]  box_y;
    logic [SIZE_W-1:0] box_width;
    logic [SIZE_W-1:0] box_height;
  } box_t;

  typedef struct packed {
    logic               kept;
    logic               duplicate;
    logic [SLOT_W-1:0]  match_slot;
    logic               table_full;
    logic [COUNT_W-1:0] stored_count;
  } verdict_t;

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] wide;
    logic [SIZE_W-1:0] tall;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             flush;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } cmd_t;

  // Datapath to controller: one compare result per cycle, in slot order.
  typedef struct packed {
    logic             res_valid;
    logic             res_hit;
    logic [IDX_W-1:0] res_idx;
  } stat_t;

endpackage

// ----- design/box_overlap_deduplicator.sv -----
// Top level of the box overlap deduplicator: controller, datapath, checks.
// A request is scanned against every region held after any list restart, in slot order,
//   stopping at the first hit; an empty table has nothing to scan.
// The scan reads one entry per cycle through a three-stage compare pipeline; a new request
//   is taken only after the last verdict is offered, and a stalled verdict output holds it off.
// Reset: synchronous, active high; empties the table and drops any pending verdict.
`timescale 1ns / 1ps

module box_overlap_deduplicator (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  output logic              box_ready,
  input  bod_pkg::box_t     box,
  output logic              verdict_valid,
  input  logic              verdict_ready,
  output bod_pkg::verdict_t verdict
);
  import bod_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request: clear on a new list, scan stored regions in slot
  // order, stop at the first overlap, then store or drop and report.
  bod_controller u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .box_valid     (box_valid),
    .box_ready     (box_ready),
    .first_of_list (box.first_of_list),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict),
    .cmd           (cmd),
    .stat          (stat)
  );

  // Hold the region table and run the overlap test, one entry per cycle.
  bod_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .box  (box),
    .cmd  (cmd),
    .stat (stat)
  );

  // Every verdict has exactly one outcome.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> $onehot({verdict.kept, verdict.duplicate, verdict.table_full}))
    else $error("verdict outcome not unique");

  // A taken request blocks the input until its verdict is decided.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (box_valid && box_ready) |=> !box_ready)
    else $error("input ready right after accepting a request");

  // The table never reports more regions than it holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict.stored_count <= COUNT_W'(MAX_REGIONS)))
    else $error("stored count beyond table size");

  // A duplicate points at a region that is held.
  a_slot_held: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && verdict.duplicate) |->
      (COUNT_W'(verdict.match_slot) < verdict.stored_count))
    else $error("duplicate matched an empty slot");

endmodule

// ----- design/bod_datapath.sv -----
// Region table and pipelined overlap compare for the box overlap deduplicator.
`timescale 1ns / 1ps

module bod_datapath (
  input  logic          clk,
  input  logic          rst,
  input  bod_pkg::box_t box,
  input  bod_pkg::cmd_t cmd,
  output bod_pkg::stat_t stat
);
  import bod_pkg::*;

  entry_t             mem [MAX_REGIONS];
  entry_t             cur;
  logic [AREA_W-1:0]  area;

  logic               s1_valid;
  logic [IDX_W-1:0]   s1_idx;
  entry_t             s1_entry;

  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic [SIZE_W-1:0]  s2_iw;
  logic [SIZE_W-1:0]  s2_ih;
  logic [AREA_W-1:0]  s2_other;

  logic               s3_valid;
  logic [IDX_W-1:0]   s3_idx;
  logic [AREA_W-1:0]  s3_inter;
  logic [AREA_W-1:0]  s3_small;

  logic [EDGE_W-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic [EDGE_W-1:0]  cur_r, cur_b, ent_r, ent_b;
  logic [SIZE_W-1:0]  iw, ih;
  logic [AREA_W+2:0]  lhs, rhs;

  // Current rectangle and its area.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.left <= box.box_x;
      cur.top  <= box.box_y;
      cur.wide <= box.box_width;
      cur.tall <= box.box_height;
    end
    area <= AREA_W'(cur.wide) * AREA_W'(cur.tall);
  end

  // Region table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= cur;
    end
    if (cmd.rd_en) begin
      s1_entry <= mem[cmd.rd_idx];
    end
  end

  // Span overlap on both axes.
  always_comb begin
    cur_r = EDGE_W'(cur.left) + EDGE_W'(cur.wide);
    cur_b = EDGE_W'(cur.top) + EDGE_W'(cur.tall);
    ent_r = EDGE_W'(s1_entry.left) + EDGE_W'(s1_entry.wide);
    ent_b = EDGE_W'(s1_entry.top) + EDGE_W'(s1_entry.tall);
    lo_x  = (cur.left > s1_entry.left) ? EDGE_W'(cur.left) : EDGE_W'(s1_entry.left);
    lo_y  = (cur.top > s1_entry.top) ? EDGE_W'(cur.top) : EDGE_W'(s1_entry.top);
    hi_x  = (cur_r < ent_r) ? cur_r : ent_r;
    hi_y  = (cur_b < ent_b) ? cur_b : ent_b;
    // overlap never exceeds either length, so it fits a size field
    iw    = (hi_x > lo_x) ? SIZE_W'(hi_x - lo_x) : '0;
    ih    = (hi_y > lo_y) ? SIZE_W'(hi_y - lo_y) : '0;
  end

  always_ff @(posedge clk) begin
    s2_idx   <= s1_idx;
    s2_iw    <= iw;
    s2_ih    <= ih;
    s2_other <= AREA_W'(s1_entry.wide) * AREA_W'(s1_entry.tall);
    s3_idx   <= s2_idx;
    s3_inter <= AREA_W'(s2_iw) * AREA_W'(s2_ih);
    s3_small <= (area < s2_other) ? area : s2_other;
    s1_idx   <= cmd.rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // 5 * inter > 3 * small, by shift and add.
  always_comb begin
    lhs = (AREA_W+3)'({s3_inter, 2'b00}) + (AREA_W+3)'(s3_inter);
    rhs = (AREA_W+3)'({s3_small, 1'b0}) + (AREA_W+3)'(s3_small);
    stat.res_valid = s3_valid;
    stat.res_hit   = lhs > rhs;
    stat.res_idx   = s3_idx;
  end

endmodule

// ----- design/bod_controller.sv -----
// Sequencer for the box overlap deduplicator: scan, decide, store, report.
`timescale 1ns / 1ps

module bod_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  output logic              box_ready,
  input  logic              first_of_list,
  output logic              verdict_valid,
  input  logic              verdict_ready,
  output bod_pkg::verdict_t verdict,
  output bod_pkg::cmd_t     cmd,
  input  bod_pkg::stat_t    stat
);
  import bod_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] issue_idx, issue_idx_next;
  logic [CNT_W-1:0] res_cnt, res_cnt_next;
  logic             dup_hit, dup_hit_next;
  logic [IDX_W-1:0] hit_idx, hit_idx_next;
  logic             out_load;
  logic             room;
  verdict_t         verdict_next;

  assign box_ready = (state == ST_IDLE);
  assign room      = count < CNT_W'(MAX_REGIONS);

  always_comb begin
    state_next     = state;
    count_next     = count;
    issue_idx_next = issue_idx;
    res_cnt_next   = res_cnt;
    dup_hit_next   = dup_hit;
    hit_idx_next   = hit_idx;
    out_load       = 1'b0;
    cmd            = '0;
    cmd.rd_idx     = issue_idx[IDX_W-1:0];
    cmd.wr_idx     = count[IDX_W-1:0];
    verdict_next   = '0;

    unique case (state)
      ST_IDLE: begin
        if (box_valid) begin
          cmd.load       = 1'b1;
          if (first_of_list) count_next = '0;
          issue_idx_next = '0;
          res_cnt_next   = '0;
          dup_hit_next   = 1'b0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = issue_idx < count;
        if (cmd.rd_en) issue_idx_next = issue_idx + 1'b1;
        if (stat.res_valid && stat.res_hit) begin
          cmd.flush    = 1'b1;
          dup_hit_next = 1'b1;
          hit_idx_next = stat.res_idx;
          state_next   = ST_FINISH;
        end else if (res_cnt == count) begin
          state_next = ST_FINISH;
        end else if (stat.res_valid) begin
          res_cnt_next = res_cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!verdict_valid || verdict_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (dup_hit) begin
            verdict_next.duplicate  = 1'b1;
            verdict_next.match_slot = SLOT_W'(hit_idx);
          end else if (room) begin
            cmd.wr_en         = 1'b1;
            count_next        = count + 1'b1;
            verdict_next.kept = 1'b1;
          end else begin
            verdict_next.table_full = 1'b1;
          end
          verdict_next.stored_count = COUNT_W'(count_next);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      issue_idx     <= '0;
      res_cnt       <= '0;
      dup_hit       <= 1'b0;
      verdict_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      issue_idx <= issue_idx_next;
      res_cnt   <= res_cnt_next;
      dup_hit   <= dup_hit_next;
      if (out_load) begin
        verdict_valid <= 1'b1;
      end else if (verdict_ready) begin
        verdict_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx <= hit_idx_next;
    if (out_load) verdict <= verdict_next;
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the box overlap deduplicator top level.
`timescale 1ns / 1ps

module tb_top;
  import bod_pkg::*;

  // Random part size, drain wait and watchdog limit. The limit covers about 600
  // requests, each with the longest sender gap, the longest receiver stall and the
  // scan, several times over.
  localparam int RANDOM_REQUESTS = 520;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 600_000;
  localparam int POS_MAX         = (1 << POS_W) - 1;
  localparam int SIZE_MAX        = (1 << SIZE_W) - 1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     box_valid = 1'b0;
  logic     box_ready;
  box_t     box = '0;
  logic     verdict_valid;
  logic     verdict_ready = 1'b0;
  verdict_t verdict;

  // Mirror of the region table, with its own copy of the count.
  entry_t   mirror_regions [MAX_REGIONS];
  int       mirror_count = 0;
  verdict_t pending_verdicts [$];
  verdict_t oldest_verdict;

  int error_count   = 0;
  int request_count = 0;
  int checked_count = 0;
  int kept_seen     = 0;
  int dup_seen      = 0;
  int full_seen     = 0;
  bit idle_off      = 1'b0;

  box_overlap_deduplicator uut (
    .clk           (clk),
    .rst           (rst),
    .box_valid     (box_valid),
    .box_ready     (box_ready),
    .box           (box),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Length of the overlap of [a0, a0+al) and [b0, b0+bl); 0 when disjoint.
  function automatic longint unsigned span_len(longint unsigned a0, longint unsigned al,
                                               longint unsigned b0, longint unsigned bl);
    longint unsigned lo;
    longint unsigned hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // Judge one rectangle against the mirror table and update it, exactly as
  // the block must: first entry in slot order beyond 0.6 of the smaller area.
  function automatic verdict_t classify_box(box_t b);
    verdict_t        v;
    bit              hit;
    longint unsigned area;
    longint unsigned inter;
    longint unsigned other;
    longint unsigned least;
    v    = '0;
    hit  = 1'b0;
    if (b.first_of_list)
      mirror_count = 0;
    area = longint'(b.box_width) * longint'(b.box_height);
    for (int i = 0; i < mirror_count; i++) begin
      if (!hit) begin
        inter = span_len(b.box_x, b.box_width, mirror_regions[i].left, mirror_regions[i].wide) *
                span_len(b.box_y, b.box_height, mirror_regions[i].top, mirror_regions[i].tall);
        other = longint'(mirror_regions[i].wide) * longint'(mirror_regions[i].tall);
        least = (area < other) ? area : other;
        if (5 * inter > 3 * least) begin
          hit          = 1'b1;
          v.match_slot = SLOT_W'(i);
        end
      end
    end
    if (!hit) begin
      if (mirror_count < MAX_REGIONS) begin
        mirror_regions[mirror_count] = '{left: b.box_x, top: b.box_y,
                                         wide: b.box_width, tall: b.box_height};
        mirror_count++;
        v.kept = 1'b1;
      end else begin
        v.table_full = 1'b1;
      end
    end
    v.duplicate    = hit;
    v.stored_count = COUNT_W'(mirror_count);
    return v;
  endfunction

  // Idle length for either side: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (idle_off)
      return 0;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(3, 1);
    if (r < 96)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic box_t make_rect(bit first, int x, int y, int w, int h);
    box_t b;
    b.first_of_list = first;
    b.box_x         = POS_W'(x);
    b.box_y         = POS_W'(y);
    b.box_width     = SIZE_W'(w);
    b.box_height    = SIZE_W'(h);
    return b;
  endfunction

  function automatic int clamp_to(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // Offset a value by up to +/- reach, kept within 0..hi.
  function automatic int jitter(int v, int reach, int hi);
    return clamp_to(v + int'($urandom_range(2 * reach)) - reach, hi);
  endfunction

  // Draw one rectangle: a near copy of an earlier one in the list, a fully
  // random one over the whole field ranges, or a typical small one.
  function automatic box_t make_random_box(const ref box_t recent [$], int dup_pct);
    box_t b;
    box_t src;
    int   r;
    r = $urandom_range(99);
    if (recent.size() > 0 && r < dup_pct) begin
      src = recent[$urandom_range(recent.size() - 1)];
      b = make_rect(1'b0,
                    jitter(src.box_x, src.box_width / 3 + 1, POS_MAX),
                    jitter(src.box_y, src.box_height / 3 + 1, POS_MAX),
                    jitter(src.box_width, src.box_width / 4 + 1, SIZE_MAX),
                    jitter(src.box_height, src.box_height / 4 + 1, SIZE_MAX));
    end else if (r < dup_pct + 10) begin
      b = make_rect(1'b0, $urandom_range(POS_MAX), $urandom_range(POS_MAX),
                    $urandom_range(SIZE_MAX), $urandom_range(SIZE_MAX));
    end else begin
      b = make_rect(1'b0, $urandom_range(POS_MAX), $urandom_range(POS_MAX),
                    $urandom_range(400), $urandom_range(400));
    end
    return b;
  endfunction

  // Send one request: idle first, then hold valid and payload until accepted.
  // Leave valid high afterwards so a back-to-back request never toggles it.
  task automatic send_box(box_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      box_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box       = b;
    box_valid = 1'b1;
    @(posedge clk);
    while (!box_ready)
      @(posedge clk);
    pending_verdicts.insert(pending_verdicts.size(), classify_box(b));
    request_count++;
    @(negedge clk);
  endtask

  // Hold off the sender until every verdict is back, then let the block settle.
  task automatic wait_drained();
    box_valid = 1'b0;
    while (pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Zero-area rectangles, the largest sizes and positions, and a list that
  // starts without the restart flag right after reset.
  task automatic test_extremes();
    send_box(make_rect(1'b0, 0, 0, 0, 0));
    send_box(make_rect(1'b0, 0, 0, 0, 0));               // zero area is never a duplicate
    send_box(make_rect(1'b0, 0, 0, 4096, 4096));
    send_box(make_rect(1'b0, 0, 0, 4096, 4096));         // duplicate of the big one
    send_box(make_rect(1'b0, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX));
    send_box(make_rect(1'b0, 100, 100, 0, 50));          // zero width inside the big box
  endtask

  // Overlap exactly at 0.6 is not enough; above it matches the first slot hit.
  task automatic test_threshold();
    send_box(make_rect(1'b1, 0, 0, 10, 10));
    send_box(make_rect(1'b0, 4, 0, 10, 10));             // 60 of 100: kept
    send_box(make_rect(1'b0, 3, 0, 10, 10));             // 70 of 100: slot 0
    send_box(make_rect(1'b0, 5, 0, 10, 10));             // only slot 1 beyond threshold
    send_box(make_rect(1'b0, 2, 2, 3, 3));               // small box held inside slot 0
  endtask

  // Fill the table, then drop a unique rectangle, match the last slot, restart.
  task automatic test_table_full();
    send_box(make_rect(1'b1, 0, 0, 100, 100));
    for (int i = 1; i < MAX_REGIONS; i++)
      send_box(make_rect(1'b0, i * 256, 0, 100, 100));
    send_box(make_rect(1'b0, 0, 2048, 100, 100));        // unique, no room
    send_box(make_rect(1'b0, (MAX_REGIONS - 1) * 256, 0, 100, 100));
    send_box(make_rect(1'b1, 0, 2048, 100, 100));        // restart on a full table
  endtask

  // Lists of random length: mostly restart-flagged lists with a mix of near
  // copies and fresh rectangles, plus stray restarts and unflagged list heads.
  task automatic test_random_lists();
    box_t recent [$];
    box_t b;
    int   sent;
    int   list_len;
    int   dup_pct;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      idle_off = ($urandom_range(5) == 0);
      list_len = ($urandom_range(99) < 15) ? $urandom_range(30, 17) : $urandom_range(12, 1);
      dup_pct  = $urandom_range(60, 10);
      recent.delete();
      for (int k = 0; k < list_len && sent < RANDOM_REQUESTS; k++) begin
        b = make_random_box(recent, dup_pct);
        b.first_of_list = (k == 0 && $urandom_range(9) != 0) || ($urandom_range(49) == 0);
        if (b.first_of_list)
          recent.delete();
        send_box(b);
        recent.insert(recent.size(), b);
        sent++;
      end
      if ($urandom_range(9) == 0)
        wait_drained();
    end
    idle_off = 1'b0;
  endtask

  // Receiver: stall at random, with stretches of steady ready.
  initial begin
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        verdict_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      verdict_ready = 1'b1;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
  end

  // Compare each accepted verdict with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (!rst && verdict_valid && verdict_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no request pending");
        error_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        checked_count++;
        if (verdict.kept !== oldest_verdict.kept) begin
          $error("kept: expected %0d, got %0d", oldest_verdict.kept, verdict.kept);
          error_count++;
        end
        if (verdict.duplicate !== oldest_verdict.duplicate) begin
          $error("duplicate: expected %0d, got %0d",
                 oldest_verdict.duplicate, verdict.duplicate);
          error_count++;
        end
        if (verdict.match_slot !== oldest_verdict.match_slot) begin
          $error("match_slot: expected %0d, got %0d",
                 oldest_verdict.match_slot, verdict.match_slot);
          error_count++;
        end
        if (verdict.table_full !== oldest_verdict.table_full) begin
          $error("table_full: expected %0d, got %0d",
                 oldest_verdict.table_full, verdict.table_full);
          error_count++;
        end
        if (verdict.stored_count !== oldest_verdict.stored_count) begin
          $error("stored_count: expected %0d, got %0d",
                 oldest_verdict.stored_count, verdict.stored_count);
          error_count++;
        end
        kept_seen += verdict.kept;
        dup_seen  += verdict.duplicate;
        full_seen += verdict.table_full;
      end
    end
  end

  // Watchdog: give up on a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    wait_drained();
    test_threshold();
    wait_drained();
    test_table_full();
    wait_drained();
    test_random_lists();
    wait_drained();
    $display("Covered %0d requests over directed and random lists, %0d verdicts checked.",
             request_count, checked_count);
    $display("Verdicts seen: %0d kept, %0d duplicates, %0d dropped on a full table.",
             kept_seen, dup_seen, full_seen);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
design/bod_pkg.sv
design/bod_datapath.sv
design/bod_controller.sv
design/box_overlap_deduplicator.sv
tb/tb_top.sv
